FILE: hdl/lstc_pkg.sv
// Shared types and constants for the lazy segment tree color set block.
`timescale 1ns / 1ps
package lstc_pkg;

    localparam int LEAVES   = 4096;
    localparam int TREE_LVL = $clog2(LEAVES);
    localparam int NODE_AW  = TREE_LVL + 1;
    localparam int NODE_CNT = 2 * LEAVES;
    localparam int COLORS   = 61;
    localparam int COLOR_W  = 6;
    localparam int PEND_W   = COLOR_W + 1;
    localparam int CFG_W    = 13;
    localparam int POS_W    = 12;
    localparam int DEPTH_W  = $clog2(TREE_LVL + 1);
    localparam int CNT_W    = 6;

    localparam logic MODE_ASSIGN = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [POS_W-1:0]   range_low;
        logic [POS_W-1:0]   range_high;
        logic [COLOR_W-1:0] color;
    } t_in_word;

    typedef struct packed {
        logic [COLORS-1:0] color_set;
        logic [CNT_W-1:0]  distinct_count;
        logic              range_error;
    } t_out_word;

    typedef struct packed {
        logic               set_we;
        logic [NODE_AW-1:0] set_addr;
        logic [COLORS-1:0]  set_data;
        logic               pend_we;
        logic [NODE_AW-1:0] pend_addr;
        logic [PEND_W-1:0]  pend_data;
    } t_mem_wr;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_EVAL,
        ST_PL,
        ST_PR,
        ST_ACT,
        ST_FIN
    } t_state;

endpackage

FILE: hdl/lstc_node_mem.sv
// Node store holding the color set and the pending assignment of every tree node.
`timescale 1ns / 1ps
module lstc_node_mem
    import lstc_pkg::*;
(
    input  logic               i_clk,
    input  t_mem_wr            i_wr,
    input  logic [NODE_AW-1:0] i_rd_addr,
    output logic [COLORS-1:0]  o_rd_set,
    output logic [PEND_W-1:0]  o_rd_pend
);

    logic [COLORS-1:0] r_sets [0:NODE_CNT-1];
    logic [PEND_W-1:0] r_pend [0:NODE_CNT-1];

    always_ff @(posedge i_clk) begin
        if (i_wr.set_we) begin
            r_sets[i_wr.set_addr] <= i_wr.set_data;
        end
        o_rd_set <= r_sets[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.pend_we) begin
            r_pend[i_wr.pend_addr] <= i_wr.pend_data;
        end
        o_rd_pend <= r_pend[i_rd_addr];
    end

endmodule

FILE: hdl/lazy_segment_tree_color_set_core.sv
// Top level of the lazy segment tree color set block.
//
//   channel  | handshake               | word
//   ---------+-------------------------+------------------------------
//   input    | start high, busy low    | t_in_word
//   result   | o_result_strobe, 1 cyc  | t_out_word
//   config   | i_cfg_valid/o_cfg_ready | elements_in_use, 13 bits
//
// Each visited node is read (ST_RD), then evaluated and written back (ST_EVAL); a pending
// assignment is pushed to both children (ST_PL, ST_PR) before the walk moves on (ST_ACT), and
// a partly covered node is merged from its children on the way back up (ST_FIN).
// Invalid or ignored items never leave idle; an invalid query returns a range-error word.
// After reset a clearing pass over all 8192 nodes empties the node store, busy high.
// The receiver cannot stall; each result shows for one cycle.
`timescale 1ns / 1ps
module lazy_segment_tree_color_set_core
    import lstc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_in_word         i_in,
    output logic             o_result_strobe,
    output t_out_word        o_out,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_state               r_state, n_state;
    logic [CFG_W-1:0]     r_cfg;
    logic [NODE_AW-1:0]   r_node, n_node;
    logic [DEPTH_W-1:0]   r_depth, n_depth;
    logic                 r_mode, n_mode;
    logic [POS_W-1:0]     r_a, n_a, r_b, n_b;
    logic [COLOR_W-1:0]   r_color, n_color;
    logic [COLORS-1:0]    r_res, n_res;
    logic [PEND_W-1:0]    r_cp, n_cp;
    logic                 r_act, n_act;
    logic [COLORS-1:0]    r_acc [0:TREE_LVL];
    logic [NODE_AW-1:0]   r_clr;
    logic                 r_strobe, n_strobe;
    t_out_word            r_out, n_out;

    t_mem_wr              mem_wr;
    logic [COLORS-1:0]    rd_set;
    logic [PEND_W-1:0]    rd_pend;

    logic [CFG_W-1:0]     cap;
    logic                 in_ok;
    logic                 accept;
    logic [POS_W-1:0]     lo, hi, span_mask;
    logic                 leaf, disjoint, covered;
    logic [COLORS-1:0]    eff_set, col_hot;

    lstc_node_mem u_mem (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_addr (r_node),
        .o_rd_set  (rd_set),
        .o_rd_pend (rd_pend)
    );

    assign o_cfg_ready     = 1'b1;
    assign busy            = (r_state != ST_IDLE);
    assign accept          = start && !busy;
    assign o_result_strobe = r_strobe;
    assign o_out           = r_out;

    assign cap   = (r_cfg > CFG_W'(LEAVES)) ? CFG_W'(LEAVES) : r_cfg;
    assign in_ok = (i_in.range_low <= i_in.range_high) && ({1'b0, i_in.range_high} < cap);

    assign span_mask = {POS_W{1'b1}} >> r_depth;
    assign lo        = POS_W'(r_node << (DEPTH_W'(TREE_LVL) - r_depth)) & ~span_mask;
    assign hi        = lo | span_mask;
    assign leaf      = (r_depth == DEPTH_W'(TREE_LVL));
    assign disjoint  = (r_b < lo) || (hi < r_a);
    assign covered   = (r_a <= lo) && (hi <= r_b);
    assign eff_set   = rd_pend[PEND_W-1] ? (COLORS'(1) << rd_pend[COLOR_W-1:0]) : rd_set;
    assign col_hot   = COLORS'(1) << r_color;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == NODE_AW'(NODE_CNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && in_ok && (i_in.mode == MODE_QUERY || i_in.color < COLOR_W'(COLORS))) begin
                    n_state = ST_RD;
                end
            end
            ST_RD:   n_state = ST_EVAL;
            ST_EVAL: n_state = (rd_pend[PEND_W-1] && !leaf) || (covered && !leaf && r_mode == MODE_ASSIGN)
                               ? ST_PL : ST_ACT;
            ST_PL:   n_state = ST_PR;
            ST_PR:   n_state = ST_ACT;
            ST_ACT: begin
                if (r_act) begin
                    n_state = ST_RD;
                end else if (r_depth == '0) begin
                    n_state = ST_IDLE;
                end else if (!r_node[0]) begin
                    n_state = ST_RD;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN:  n_state = ST_ACT;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_node   = r_node;
        n_depth  = r_depth;
        n_mode   = r_mode;
        n_a      = r_a;
        n_b      = r_b;
        n_color  = r_color;
        n_res    = r_res;
        n_cp     = r_cp;
        n_act    = r_act;
        n_strobe = 1'b0;
        n_out    = r_out;
        mem_wr   = '0;
        case (r_state)
            ST_CLEAR: begin
                mem_wr.set_we    = 1'b1;
                mem_wr.set_addr  = r_clr;
                mem_wr.pend_we   = 1'b1;
                mem_wr.pend_addr = r_clr;
            end
            ST_IDLE: begin
                n_mode  = i_in.mode;
                n_a     = i_in.range_low;
                n_b     = i_in.range_high;
                n_color = i_in.color;
                n_node  = NODE_AW'(1);
                n_depth = '0;
                if (accept && i_in.mode == MODE_QUERY && !in_ok) begin
                    n_strobe = 1'b1;
                    n_out    = '{color_set: '0, distinct_count: '0, range_error: 1'b1};
                end
            end
            ST_EVAL: begin
                mem_wr.set_we    = 1'b1;
                mem_wr.set_addr  = r_node;
                mem_wr.set_data  = eff_set;
                mem_wr.pend_we   = 1'b1;
                mem_wr.pend_addr = r_node;
                mem_wr.pend_data = '0;
                n_cp  = rd_pend;
                n_act = 1'b0;
                if (disjoint) begin
                    n_res = (r_mode == MODE_ASSIGN) ? eff_set : '0;
                end else if (covered) begin
                    if (r_mode == MODE_ASSIGN) begin
                        mem_wr.set_data = col_hot;
                        n_cp            = {1'b1, r_color};
                        n_res           = col_hot;
                    end else begin
                        n_res = eff_set;
                    end
                end else begin
                    n_act = 1'b1;
                end
            end
            ST_PL: begin
                mem_wr.pend_we   = 1'b1;
                mem_wr.pend_addr = NODE_AW'({r_node, 1'b0});
                mem_wr.pend_data = r_cp;
            end
            ST_PR: begin
                mem_wr.pend_we   = 1'b1;
                mem_wr.pend_addr = NODE_AW'({r_node, 1'b1});
                mem_wr.pend_data = r_cp;
            end
            ST_ACT: begin
                if (r_act) begin
                    n_node  = NODE_AW'({r_node, 1'b0});
                    n_depth = r_depth + DEPTH_W'(1);
                end else if (r_depth == '0) begin
                    if (r_mode == MODE_QUERY) begin
                        n_strobe = 1'b1;
                        n_out    = '{color_set: r_res,
                                     distinct_count: CNT_W'($countones(r_res)),
                                     range_error: 1'b0};
                    end
                end else if (!r_node[0]) begin
                    n_node = r_node + NODE_AW'(1);
                end else begin
                    n_node  = r_node >> 1;
                    n_depth = r_depth - DEPTH_W'(1);
                end
            end
            ST_FIN: begin
                n_res = r_acc[r_depth];
                n_act = 1'b0;
                if (r_mode == MODE_ASSIGN) begin
                    mem_wr.set_we   = 1'b1;
                    mem_wr.set_addr = r_node;
                    mem_wr.set_data = r_acc[r_depth];
                end
            end
            default: begin
                n_act = r_act;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_cfg    <= CFG_W'(LEAVES);
            r_clr    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + NODE_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_node  <= n_node;
        r_depth <= n_depth;
        r_mode  <= n_mode;
        r_a     <= n_a;
        r_b     <= n_b;
        r_color <= n_color;
        r_res   <= n_res;
        r_cp    <= n_cp;
        r_act   <= n_act;
        r_out   <= n_out;
        if (r_state == ST_ACT) begin
            if (r_act) begin
                r_acc[r_depth] <= '0;
            end else if (r_depth != '0) begin
                r_acc[r_depth - DEPTH_W'(1)] <= r_acc[r_depth - DEPTH_W'(1)] | r_res;
            end
        end
    end

endmodule

FILE: hdl/lstc_checker.sv
// Port-level checker for the lazy segment tree color set block, with its bind.
`timescale 1ns / 1ps
module lstc_checker
    import lstc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input t_in_word  i_in,
    input logic      o_result_strobe,
    input t_out_word o_out
);

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("Block is not busy clearing after reset.");

    a_assign_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_in.mode == MODE_ASSIGN |=> !o_result_strobe)
        else $error("An assign item produced a result word.");

    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> o_out.distinct_count == CNT_W'($countones(o_out.color_set)))
        else $error("Distinct count does not match the color set.");

    a_error_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe && o_out.range_error |-> o_out.color_set == '0)
        else $error("A range error word carries colors.");

endmodule

bind lazy_segment_tree_color_set_core lstc_checker u_lstc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_in            (i_in),
    .o_result_strobe (o_result_strobe),
    .o_out           (o_out)
);

FILE: dv/lazy_segment_tree_color_set_core_test.sv
// Testbench for the lazy segment tree color set block, checked against a position-array model.
`timescale 1ns / 1ps
module lazy_segment_tree_color_set_core_test;
    import lstc_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE      = 400;

    class color_scoreboard;
        int           slot_color[LEAVES];
        int unsigned  in_use;
        t_out_word    pending_sets[$];
        int           errors;

        function new();
            foreach (slot_color[i]) slot_color[i] = -1;
            in_use = LEAVES;
            errors = 0;
        endfunction

        function void note_word(t_in_word w);
            int unsigned lim;
            bit          ok;
            t_out_word   res;
            lim = (in_use > LEAVES) ? LEAVES : in_use;
            ok  = (w.range_low <= w.range_high) && (w.range_high < lim);
            if (w.mode == MODE_ASSIGN) begin
                if (ok && w.color < COLORS)
                    for (int p = w.range_low; p <= w.range_high; p++) slot_color[p] = w.color;
                return;
            end
            res = '0;
            if (!ok) begin
                res.range_error = 1'b1;
            end else begin
                for (int p = w.range_low; p <= w.range_high; p++)
                    if (slot_color[p] >= 0) res.color_set[slot_color[p]] = 1'b1;
                res.distinct_count = CNT_W'($countones(res.color_set));
            end
            pending_sets = {pending_sets, res};
        endfunction

        task report(string what);
            $display("error at %0t: %s", $time, what);
            errors++;
        endtask

        task check_word(t_out_word got);
            t_out_word exp_w;
            if (pending_sets.size() == 0) begin
                report("result word with nothing expected");
                return;
            end
            exp_w = pending_sets.pop_front();
            if (got.color_set !== exp_w.color_set)
                report($sformatf("color_set %h, want %h", got.color_set, exp_w.color_set));
            if (got.distinct_count !== exp_w.distinct_count)
                report($sformatf("distinct_count %0d, want %0d",
                                 got.distinct_count, exp_w.distinct_count));
            if (got.range_error !== exp_w.range_error)
                report($sformatf("range_error %b, want %b",
                                 got.range_error, exp_w.range_error));
        endtask
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    t_in_word         i_in = '0;
    logic             o_result_strobe;
    t_out_word        o_out;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data = '0;

    color_scoreboard  board = new();
    int unsigned      cycles = 0;

    lazy_segment_tree_color_set_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_in(i_in),
        .o_result_strobe(o_result_strobe), .o_out(o_out), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe) board.check_word(o_out);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("lazy_segment_tree_color_set_core: mismatch");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    function automatic t_in_word rand_word();
        logic [31:0] r;
        r = $urandom();
        return r[$bits(t_in_word)-1:0];
    endfunction

    task automatic send_word(t_in_word w, bit allow_gap);
        int unsigned gap;
        start <= 1'b1;
        i_in  <= w;
        do @(posedge i_clk); while (busy);
        board.note_word(w);
        gap = allow_gap ? pick_gap() : 0;
        if (gap > 0) begin
            start <= 1'b0;
            i_in  <= rand_word();
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.pending_sets.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_in_use(int unsigned v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v[CFG_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        board.in_use = v[CFG_W-1:0];
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in_word make_word(int unsigned lim);
        t_in_word w;
        int unsigned r, span;
        w = rand_word();
        r = $urandom_range(0, 99);
        w.mode = ($urandom_range(0, 99) < 55) ? MODE_ASSIGN : MODE_QUERY;
        w.color = ($urandom_range(0, 19) == 0) ? COLOR_W'($urandom_range(COLORS, 63))
                                               : COLOR_W'($urandom_range(0, COLORS - 1));
        if (r < 85 && lim > 0) begin
            w.range_low = POS_W'($urandom_range(0, lim - 1));
            span = ($urandom_range(0, 9) == 0) ? lim : 16;
            w.range_high = POS_W'(w.range_low + $urandom_range(0, span - 1));
            if (w.range_high >= lim || w.range_high < w.range_low) w.range_high = POS_W'(lim - 1);
        end
        return w;
    endfunction

    function automatic t_in_word mk(logic m, int unsigned lo, int unsigned hi,
                                    int unsigned c);
        t_in_word w;
        w.mode = m;
        w.range_low = POS_W'(lo);
        w.range_high = POS_W'(hi);
        w.color = COLOR_W'(c);
        return w;
    endfunction

    task automatic run_random(int unsigned count);
        int unsigned lim;
        lim = (board.in_use > LEAVES) ? LEAVES : board.in_use;
        repeat (count) send_word(make_word(lim), $urandom_range(0, 3) != 0);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        write_in_use(LEAVES);

        send_word(mk(MODE_QUERY, 0, 4095, 0), 1);
        send_word(mk(MODE_ASSIGN, 0, 4095, 0), 1);
        send_word(mk(MODE_QUERY, 0, 4095, 0), 0);
        send_word(mk(MODE_ASSIGN, 4095, 4095, 60), 0);
        send_word(mk(MODE_ASSIGN, 0, 0, 33), 1);
        send_word(mk(MODE_ASSIGN, 100, 200, 61), 0);
        send_word(mk(MODE_ASSIGN, 100, 200, 63), 0);
        send_word(mk(MODE_ASSIGN, 2048, 2047, 5), 0);
        send_word(mk(MODE_QUERY, 0, 4095, 0), 0);
        send_word(mk(MODE_QUERY, 4095, 4095, 0), 1);
        send_word(mk(MODE_QUERY, 0, 0, 63), 0);
        send_word(mk(MODE_QUERY, 2048, 2047, 0), 0);
        send_word(mk(MODE_QUERY, 1, 4094, 0), 0);
        send_word(mk(MODE_ASSIGN, 1365, 2730, 42), 0);
        send_word(mk(MODE_QUERY, 1364, 2731, 0), 1);
        run_random(500);
        drain();

        write_in_use(8191);
        run_random(200);
        drain();
        write_in_use(1);
        send_word(mk(MODE_ASSIGN, 0, 0, 7), 0);
        send_word(mk(MODE_QUERY, 0, 1, 0), 0);
        send_word(mk(MODE_QUERY, 0, 0, 0), 0);
        run_random(60);
        drain();
        write_in_use(0);
        send_word(mk(MODE_ASSIGN, 0, 0, 9), 0);
        send_word(mk(MODE_QUERY, 0, 0, 0), 0);
        run_random(30);
        drain();
        write_in_use($urandom_range(2, 600));
        run_random(300);
        drain();
        write_in_use(LEAVES);
        send_word(mk(MODE_QUERY, 0, 4095, 0), 0);
        run_random(300);
        drain();

        if (board.pending_sets.size() != 0) board.report("results still expected at end");
        if (board.errors == 0) begin
            $display("lazy_segment_tree_color_set_core: match");
        end else begin
            $display("lazy_segment_tree_color_set_core: mismatch");
        end
        $finish;
    end

endmodule
